// File: design/h2a_pkg.sv
`default_nettype none

package h2a_pkg;

	// item operations
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PROC = 1'b1;

	// result status codes
	localparam logic [1:0] ST_ENC  = 2'd0;
	localparam logic [1:0] ST_PASS = 2'd1;
	localparam logic [1:0] ST_REJ  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_SIZE  = 2'd0;
	localparam logic [1:0] REG_MODE  = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	// field and register widths
	localparam int CHAR_W  = 8;
	localparam int SIZE_W  = 9;
	localparam int LIMIT_W = 16;
	localparam int COUNT_W = 17;
	localparam int CARRY_W = 5;
	localparam int DIV_W   = 9;

	// defaults and limits
	localparam int DEF_TABLE_DEPTH = 256;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd11;
	localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd11;

	// character constants
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [3:0]        DIGIT_TEN = 4'd10;

	// divider result handed to the sequencer
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_res_t;

endpackage

`default_nettype wire

// File: design/h2a_div.sv
`default_nettype none

module h2a_div import h2a_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output div_res_t              res
);

	localparam int CNT_W = $clog2(DIV_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;

	logic [DIV_W:0]   shifted;
	logic [DIV_W+1:0] diff;
	logic             ge;

	// one restoring step: bring down the next dividend bit and try the subtract
	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		diff    = {1'b0, shifted} - {2'b00, divisor};
		ge      = ~diff[DIV_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

`default_nettype wire

// File: design/hex_to_alphabet_encoder.sv
// Hex-to-alphabet encoder. Items on the item channel either load one alphabet
// table entry (operation 0) or process one stream character (operation 1).
// In encode mode, pairs of hex digits form bytes; each byte plus the running
// carry is divided by the alphabet size, the quotient becomes the new carry and
// the remainder selects the emitted table character (status 0). Whitespace is
// skipped and the first other non-hex character stops the stream until reset.
// In filter mode each character is returned with status 1 if it is among the
// first alphabet_size table entries and status 2 if not. A load item, a
// skipped or ignored character and the first digit of a pair are handled in
// the idle state; the digit that completes a byte goes through the 9-step
// iterative divider and then the registered table read; a filter character
// reads and compares one table entry at a time, up to alphabet_size entries,
// and stops at the first match. The item channel stalls while a character is
// in work; a finished word waits in the output register without holding up
// the next item. The table has no reset and must be loaded before it is used.
// Configuration registers may be written only while the block is idle.

`default_nettype none

module hex_to_alphabet_encoder import h2a_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// item channel
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               operation,
	input  wire logic [CHAR_W-1:0]  entry_index,
	input  wire logic [CHAR_W-1:0]  entry_char,
	input  wire logic [CHAR_W-1:0]  stream_char,
	// result channel
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [CHAR_W-1:0]       out_char,
	output logic [1:0]              status,
	// configuration channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [LIMIT_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam logic [SIZE_W-1:0] DEPTH_V = SIZE_W'(TABLE_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_FREAD = 3'd2;
	localparam logic [2:0] S_FCMP  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]         state_q, state_d;

	// configuration registers
	logic [SIZE_W-1:0]  size_q;
	logic               mode_q;
	logic [LIMIT_W-1:0] limit_q;

	// stream state
	logic [3:0]         high_q;
	logic               phase_q;
	logic [CARRY_W-1:0] carry_q;
	logic [COUNT_W-1:0] count_q;
	logic               stopped_q;

	// work registers
	logic [CHAR_W-1:0]  char_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic [1:0]         emit_st_q;

	// output register
	logic               res_valid_q;
	logic [CHAR_W-1:0]  res_char_q;
	logic [1:0]         res_st_q;

	// table memory
	logic [CHAR_W-1:0]  mem [TABLE_DEPTH];
	logic [CHAR_W-1:0]  rd_data_q;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;

	// divider
	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	div_res_t           div_res;

	// decode
	logic               accept;
	logic               out_free;
	logic [SIZE_W-1:0]  size_eff;
	logic               limit_hit;
	logic               proc_ok;
	logic               is_ws;
	logic               is_hex;
	logic [3:0]         digit;
	logic               count_up;
	logic               emit_load;
	logic               cnt_last;

	assign accept    = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !res_valid_q || !result_stall;

	// effective alphabet size and processing gate
	always_comb begin
		size_eff  = (size_q > DEPTH_V) ? DEPTH_V : size_q;
		limit_hit = (limit_q != '0) && (count_q[COUNT_W-1:1] >= limit_q);
		proc_ok   = (size_eff >= SIZE_MIN) && !stopped_q && !limit_hit;
		cnt_last  = (SIZE_W'(cnt_q) == (size_eff - 1'b1));
	end

	// character class and hex value
	always_comb begin
		is_ws  = (stream_char == CH_SPACE) ||
			((stream_char >= CH_TAB) && (stream_char <= CH_CR));
		is_hex = 1'b1;
		digit  = '0;
		if ((stream_char >= CH_ZERO) && (stream_char <= CH_NINE)) begin
			digit = 4'(stream_char - CH_ZERO);
		end else if ((stream_char >= CH_UA) && (stream_char <= CH_UF)) begin
			digit = 4'(stream_char - CH_UA) + DIGIT_TEN;
		end else if ((stream_char >= CH_LA) && (stream_char <= CH_LF)) begin
			digit = 4'(stream_char - CH_LA) + DIGIT_TEN;
		end else begin
			is_hex = 1'b0;
		end
	end

	// byte plus carry into the divider
	assign div_dividend = DIV_W'({high_q, digit}) + DIV_W'(carry_q);

	// sequencer
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = cnt_q;
		wr_en     = 1'b0;
		count_up  = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (operation == OP_LOAD) begin
						wr_en = ({1'b0, entry_index} < DEPTH_V);
					end else if (proc_ok) begin
						if (mode_q) begin
							state_d = S_FREAD;
						end else if (!is_ws && is_hex) begin
							count_up = 1'b1;
							if (phase_q) begin
								div_start = 1'b1;
								state_d   = S_DIV;
							end
						end
					end
				end
			end
			S_DIV: begin
				if (div_res.done) begin
					rd_en   = 1'b1;
					rd_addr = div_res.rem[ADDR_W-1:0];
					state_d = S_EMIT;
				end
			end
			S_FREAD: begin
				rd_en   = 1'b1;
				state_d = S_FCMP;
			end
			S_FCMP: begin
				if (rd_data_q == char_q) begin
					count_up = 1'b1;
					state_d  = S_EMIT;
				end else if (cnt_last) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_FREAD;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					emit_load = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and stream registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			high_q    <= '0;
			phase_q   <= 1'b0;
			carry_q   <= '0;
			count_q   <= '0;
			stopped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (count_up && (count_q != '1)) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_IDLE && accept && operation == OP_PROC && proc_ok &&
				!mode_q && !is_ws) begin
				if (!is_hex) begin
					stopped_q <= 1'b1;
				end else if (!phase_q) begin
					high_q  <= digit;
					phase_q <= 1'b1;
				end else begin
					high_q  <= '0;
					phase_q <= 1'b0;
				end
			end
			if (state_q == S_DIV && div_res.done) begin
				carry_q <= div_res.quot[CARRY_W-1:0];
			end
		end
	end

	// work registers for the character in progress
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= stream_char;
			cnt_q  <= '0;
		end else if (state_q == S_FCMP && state_d == S_FREAD) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (state_q == S_DIV) begin
			emit_st_q <= ST_ENC;
		end else if (state_q == S_FCMP) begin
			emit_st_q <= (rd_data_q == char_q) ? ST_PASS : ST_REJ;
		end
	end

	// alphabet table, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[entry_index[ADDR_W-1:0]] <= entry_char;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_RESET;
			mode_q  <= 1'b0;
			limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SIZE:  size_q  <= cfg_data[SIZE_W-1:0];
				REG_MODE:  mode_q  <= cfg_data[0];
				REG_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			res_char_q <= (emit_st_q == ST_ENC) ? rd_data_q : char_q;
			res_st_q   <= emit_st_q;
		end
	end

	assign result_valid = res_valid_q;
	assign out_char     = res_char_q;
	assign status       = res_st_q;

	// iterative divider
	h2a_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (size_eff),
		.res      (div_res)
	);

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench import h2a_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = DEF_TABLE_DEPTH;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 40;
	localparam int DRAIN_MAX   = 4000;

	typedef struct packed {
		logic              op;
		logic [CHAR_W-1:0] idx;
		logic [CHAR_W-1:0] ech;
		logic [CHAR_W-1:0] sc;
	} word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [1:0]        st;
	} result_t;

	// clock, reset and block ports
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               operation    = OP_LOAD;
	logic [CHAR_W-1:0]  entry_index  = '0;
	logic [CHAR_W-1:0]  entry_char   = '0;
	logic [CHAR_W-1:0]  stream_char  = '0;
	logic               result_stall = 1'b0;
	logic               cfg_valid    = 1'b0;
	logic [1:0]         cfg_index    = REG_SIZE;
	logic [LIMIT_W-1:0] cfg_data     = '0;
	logic               item_stall;
	logic               result_valid;
	logic [CHAR_W-1:0]  out_char;
	logic [1:0]         status;
	logic               cfg_ready;

	// expected encoder state, starts at the reset values
	logic [CHAR_W-1:0]  alpha_tbl [DEPTH];
	logic [3:0]         hi_nib        = '0;
	logic               nib_odd       = 1'b0;
	logic [CARRY_W-1:0] carry         = '0;
	logic [COUNT_W-1:0] digit_count   = '0;
	logic               stream_halted = 1'b0;
	logic [SIZE_W-1:0]  size_reg      = SIZE_RESET;
	logic               mode_reg      = 1'b0;
	logic [LIMIT_W-1:0] limit_reg     = '0;

	// table contents as seen while the stream is being built
	logic [CHAR_W-1:0]  gen_tbl [DEPTH];

	word_t   items_to_send [$];
	result_t outputs_due [$];
	word_t   in_flight;
	result_t head_due;

	bit idling    = 1'b1;
	int src_gap   = 0;
	int sink_gap  = 0;
	int n_sent    = 0;
	int n_checked = 0;
	int n_errors  = 0;
	int cycles    = 0;

	hex_to_alphabet_encoder #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.entry_index(entry_index),
		.entry_char(entry_char),
		.stream_char(stream_char),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_char(out_char),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// character classes
	function automatic int hex_value(logic [CHAR_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
		if (c >= CH_UA && c <= CH_UF) return DIGIT_TEN + c - CH_UA;
		if (c >= CH_LA && c <= CH_LF) return DIGIT_TEN + c - CH_LA;
		return -1;
	endfunction

	function automatic bit is_space(logic [CHAR_W-1:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic void count_digit();
		if (digit_count != {COUNT_W{1'b1}}) digit_count++;
	endfunction

	function automatic void add_due(logic [CHAR_W-1:0] ch, logic [1:0] st);
		result_t r;
		r.ch = ch;
		r.st = st;
		outputs_due.push_back(r);
	endfunction

	// expected behavior for one accepted word
	function automatic void encode_step(word_t w);
		int eff;
		int d;
		int sum;
		int i;
		bit hit;
		if (w.op == OP_LOAD) begin
			alpha_tbl[w.idx] = w.ech;
			return;
		end
		eff = (size_reg > DEPTH) ? DEPTH : size_reg;
		if (eff < SIZE_MIN || stream_halted) return;
		if (limit_reg != 0 && (digit_count >> 1) >= limit_reg) return;
		if (mode_reg) begin
			hit = 1'b0;
			for (i = 0; i < eff; i++)
				if (alpha_tbl[i] == w.sc) hit = 1'b1;
			if (hit) begin
				count_digit();
				add_due(w.sc, ST_PASS);
			end else begin
				add_due(w.sc, ST_REJ);
			end
			return;
		end
		if (is_space(w.sc)) return;
		d = hex_value(w.sc);
		if (d < 0) begin
			stream_halted = 1'b1;
			return;
		end
		count_digit();
		if (!nib_odd) begin
			hi_nib = d[3:0];
			nib_odd = 1'b1;
			return;
		end
		nib_odd = 1'b0;
		sum = {hi_nib, d[3:0]};
		sum = sum + carry;
		hi_nib = '0;
		carry = CARRY_W'(sum / eff);
		add_due(alpha_tbl[sum % eff], ST_ENC);
	endfunction

	// stream building
	function automatic void queue_load(logic [CHAR_W-1:0] idx, logic [CHAR_W-1:0] ch);
		word_t w;
		w.op = OP_LOAD;
		w.idx = idx;
		w.ech = ch;
		w.sc = CHAR_W'($urandom);
		gen_tbl[idx] = ch;
		items_to_send.push_back(w);
	endfunction

	function automatic void queue_char(logic [CHAR_W-1:0] c);
		word_t w;
		w.op = OP_PROC;
		w.idx = CHAR_W'($urandom);
		w.ech = CHAR_W'($urandom);
		w.sc = c;
		items_to_send.push_back(w);
	endfunction

	function automatic logic [CHAR_W-1:0] rand_hex();
		case ($urandom_range(0, 2))
			0: return CHAR_W'(CH_ZERO + $urandom_range(0, 9));
			1: return CHAR_W'(CH_UA + $urandom_range(0, 5));
			default: return CHAR_W'(CH_LA + $urandom_range(0, 5));
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] rand_space();
		int r;
		r = $urandom_range(0, 5);
		return (r == 0) ? CH_SPACE : CHAR_W'(CH_TAB + r - 1);
	endfunction

	// mostly hex digits, some whitespace and table loads
	function automatic void gen_encode(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 70) queue_char(rand_hex());
			else if (r < 82) queue_char(rand_space());
			else queue_load(CHAR_W'($urandom), CHAR_W'($urandom));
		end
	endfunction

	// table hits, random characters and loads
	function automatic void gen_filter(int n, int size);
		int r;
		int eff;
		eff = (size > DEPTH) ? DEPTH : size;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 45 && eff >= SIZE_MIN) queue_char(gen_tbl[$urandom_range(0, eff - 1)]);
			else if (r < 88) queue_char(CHAR_W'($urandom));
			else queue_load(CHAR_W'($urandom), CHAR_W'($urandom));
		end
	endfunction

	// sampled at the falling edge so the driver's updates have settled
	task automatic wait_idle();
		@(negedge clk);
		while (items_to_send.size() != 0 || item_valid || item_stall ||
			outputs_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one register write on the config channel
	task automatic write_reg(logic [1:0] idx, logic [LIMIT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SIZE: size_reg = val[SIZE_W-1:0];
			REG_MODE: mode_reg = val[0];
			default:  limit_reg = val;
		endcase
	endtask

	task automatic set_regs(int size, bit mode, int limit);
		wait_idle();
		write_reg(REG_SIZE, LIMIT_W'(size));
		write_reg(REG_MODE, LIMIT_W'(mode));
		write_reg(REG_LIMIT, LIMIT_W'(limit));
	endtask

	// word driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			src_gap = 0;
		end else begin
			if (item_valid && !item_stall) begin
				encode_step(in_flight);
				n_sent++;
			end
			if (!(item_valid && item_stall)) begin
				if (src_gap > 0) begin
					src_gap--;
					item_valid <= 1'b0;
				end else if (items_to_send.size() != 0) begin
					in_flight = items_to_send.pop_front();
					operation <= in_flight.op;
					entry_index <= in_flight.idx;
					entry_char <= in_flight.ech;
					stream_char <= in_flight.sc;
					item_valid <= 1'b1;
					if (idling && $urandom_range(0, 11) == 0) src_gap = $urandom_range(1, 18);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			sink_gap = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (outputs_due.size() == 0) begin
					$display("%0t: unexpected word out_char %02h status %0d",
						$time, out_char, status);
					n_errors++;
				end else begin
					head_due = outputs_due.pop_front();
					if (out_char !== head_due.ch) begin
						$display("%0t: out_char expected %02h actual %02h",
							$time, head_due.ch, out_char);
						n_errors++;
					end
					if (status !== head_due.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, head_due.st, status);
						n_errors++;
					end
					n_checked++;
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (idling && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 18);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: run limit reached", $time);
			$display("TEST FAILED");
			$finish;
		end
	end

	// stimulus phases
	initial begin
		int sz;
		int lim;
		int k;
		bit mode;
		bit found;
		logic [CHAR_W-1:0] c;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// fill the whole table, extremes at both ends
		for (int i = 0; i < DEPTH; i++) queue_load(CHAR_W'(i), CHAR_W'($urandom));
		queue_load(8'h00, 8'h00);
		queue_load(8'hFF, 8'hFF);

		// encode at reset settings: extreme bytes, every whitespace, mixed case
		queue_char(CH_ZERO);
		queue_char(CH_ZERO);
		queue_char(CH_LF);
		queue_char(CH_LF);
		queue_char(CH_UF);
		queue_char(CH_UF);
		queue_char(CH_NINE);
		queue_char(CH_SPACE);
		for (int i = 0; i < 5; i++) queue_char(CHAR_W'(CH_TAB + i));
		queue_char(CH_LA);
		queue_char(CH_ZERO);
		queue_char(CH_UF);

		// alphabet too small: characters ignored
		set_regs(10, 0, 0);
		queue_char(CH_NINE);
		queue_char(CH_UA);
		set_regs(0, 1, 0);
		queue_char(CHAR_W'($urandom));

		// filter: first and last entry, a miss, extreme characters
		set_regs(SIZE_MIN, 1, 0);
		queue_char(gen_tbl[0]);
		queue_char(gen_tbl[SIZE_MIN - 1]);
		do begin
			c = CHAR_W'($urandom);
			found = 1'b0;
			for (int i = 0; i < SIZE_MIN; i++)
				if (gen_tbl[i] == c) found = 1'b1;
		end while (found);
		queue_char(c);
		queue_char(8'h00);
		queue_char(8'hFF);

		// random encode phases
		set_regs(SIZE_MIN, 0, 0);
		gen_encode(15);
		set_regs(DEPTH, 0, 65535);
		gen_encode(10);
		set_regs($urandom_range(SIZE_MIN, DEPTH), 0, 0);
		gen_encode(10);
		set_regs(400, 0, 0);
		gen_encode(10);

		// byte limit hit, then raised so the stream resumes
		wait_idle();
		sz = $urandom_range(SIZE_MIN, DEPTH);
		set_regs(sz, 0, (digit_count >> 1) + 3);
		gen_encode(14);
		set_regs(sz, 0, 65535);
		gen_encode(8);
		queue_char(rand_hex());

		// filter phases, mode switch may land mid byte
		set_regs(SIZE_MIN, 1, 0);
		gen_filter(12, SIZE_MIN);
		wait_idle();
		sz = $urandom_range(SIZE_MIN, 64);
		set_regs(sz, 1, (digit_count >> 1) + 2);
		gen_filter(16, sz);
		set_regs(DEPTH, 1, 0);
		gen_filter(6, DEPTH);
		set_regs(511, 1, 0);
		gen_filter(5, 511);

		// mixed random settings
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			sz = ($urandom_range(0, 3) == 0) ? $urandom_range(257, 511)
				: $urandom_range(SIZE_MIN, DEPTH);
			case ($urandom_range(0, 2))
				0: lim = 0;
				1: lim = 65535;
				default: lim = (digit_count >> 1) + $urandom_range(1, 30);
			endcase
			mode = 1'($urandom_range(0, 1));
			set_regs(sz, mode, lim);
			if (mode) gen_filter(6, sz);
			else gen_encode(6);
		end

		// last part without idling: stream halts on a non-hex character
		wait_idle();
		idling = 1'b0;
		set_regs(SIZE_MIN, 0, 0);
		gen_encode(10);
		do c = CHAR_W'($urandom); while (hex_value(c) >= 0 || is_space(c));
		queue_char(c);
		repeat (4) queue_char(CHAR_W'($urandom));
		repeat (2) queue_load(CHAR_W'($urandom), CHAR_W'($urandom));
		set_regs(200, 1, 0);
		repeat (4) queue_char(CHAR_W'($urandom));

		// drain
		@(negedge clk);
		while (items_to_send.size() != 0 || item_valid || item_stall) @(negedge clk);
		for (k = 0; k < DRAIN_MAX && outputs_due.size() != 0; k++) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (outputs_due.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, outputs_due.size());
			n_errors++;
		end

		$display("sent %0d words, checked %0d results, %0d mismatches",
			n_sent, n_checked, n_errors);
		$display("covered encode, filter, limit stop and resume, odd alphabet sizes, halt");
		if (n_errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
design/h2a_pkg.sv
design/h2a_div.sv
design/hex_to_alphabet_encoder.sv
tb/testbench.sv
